// ===== rtl/bvm_pkg.sv =====
// Shared types, opcodes and sizes for the bytecode variable machine executor.
package bvm_pkg;

    localparam int NUM_VARIABLES   = 256;
    localparam int ARRAY_COUNT     = 16;
    localparam int ARRAY_CAPACITY  = 256;
    localparam int STRING_COUNT    = 16;
    localparam int STRING_CAPACITY = 256;
    localparam int STACK_DEPTH     = 256;

    localparam int VAR_AW   = $clog2(NUM_VARIABLES);
    localparam int CONT_W   = 4;
    localparam int ELEM_AW  = $clog2(ARRAY_CAPACITY);
    localparam int STORE_AW = CONT_W + ELEM_AW;
    localparam int STK_AW   = $clog2(STACK_DEPTH);
    localparam int SP_W     = STK_AW + 1;
    localparam int LEN_W    = 9;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CW   = $clog2(DIV_STEPS + 1);

    typedef enum logic [4:0] {
        OP_SET  = 5'd0,  OP_ADD  = 5'd1,  OP_SUB  = 5'd2,  OP_MUL  = 5'd3,
        OP_DIV  = 5'd4,  OP_MOD  = 5'd5,  OP_INC  = 5'd6,  OP_DEC  = 5'd7,
        OP_GT   = 5'd8,  OP_LT   = 5'd9,  OP_EQ   = 5'd10, OP_NE   = 5'd11,
        OP_LE   = 5'd12, OP_GE   = 5'd13, OP_END  = 5'd14, OP_JMP  = 5'd15,
        OP_CALL = 5'd16, OP_RET  = 5'd17, OP_ASET = 5'd18, OP_AGET = 5'd19,
        OP_ALEN = 5'd20, OP_SSET = 5'd21, OP_SGET = 5'd22, OP_SLEN = 5'd23,
        OP_PRN  = 5'd24, OP_PRC  = 5'd25, OP_INN  = 5'd26, OP_INCH = 5'd27,
        OP_NOP  = 5'd28, OP_ACLR = 5'd29
    } t_op;

    typedef enum logic [1:0] {
        PK_NONE = 2'd0, PK_NUM = 2'd1, PK_CHAR = 2'd2
    } t_pkind;

    typedef enum logic [1:0] {
        FLT_NONE = 2'd0, FLT_DIV0 = 2'd1, FLT_INDEX = 2'd2
    } t_fault;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_MUL, S_DIV, S_GET, S_RET
    } t_state;

    typedef enum logic [2:0] {
        R_DONE, R_MUL, R_DIV, R_GET, R_RET
    } t_route;

    typedef struct packed {
        t_op                op;
        logic [15:0]        pc;
        logic [7:0]         tgt;
        logic [CONT_W-1:0]  cont;
        logic [31:0]        a_raw;
        logic [31:0]        b_raw;
        logic               a_var;
        logic               b_var;
        logic [31:0]        con;
        logic               rd0_en;
        logic [VAR_AW-1:0]  rd0_addr;
        logic               rd1_en;
        logic [VAR_AW-1:0]  rd1_addr;
    } t_item;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_bctl;

endpackage

// ===== rtl/bvm_front.sv =====
// Front end: accepts instructions, resolves variable read ports, two-entry queue.
module bvm_front import bvm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [4:0]        i_operation,
    input  logic [15:0]       i_pc,
    input  logic [7:0]        i_target_slot,
    input  logic [CONT_W-1:0] i_container_index,
    input  logic [31:0]       i_first_operand,
    input  logic [31:0]       i_second_operand,
    input  logic              i_first_is_variable,
    input  logic              i_second_is_variable,
    input  logic [31:0]       i_console_value,
    input  t_bctl             i_ctl,
    output t_item             o_item,
    output logic              o_item_valid
);

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      dec;
    logic       accept;
    t_op        op;

    always_comb begin
        op           = t_op'(i_operation);
        dec.op       = op;
        dec.pc       = i_pc;
        dec.tgt      = i_target_slot;
        dec.cont     = i_container_index;
        dec.a_raw    = i_first_operand;
        dec.b_raw    = i_second_operand;
        dec.a_var    = i_first_is_variable;
        dec.b_var    = i_second_is_variable;
        dec.con      = i_console_value;
        dec.rd0_en   = i_first_is_variable && (i_first_operand < 32'(NUM_VARIABLES));
        dec.rd0_addr = i_first_operand[VAR_AW-1:0];
        // inc and dec read the target itself on the second port
        if (op == OP_INC || op == OP_DEC) begin
            dec.rd1_en   = (32'(i_target_slot) < 32'(NUM_VARIABLES));
            dec.rd1_addr = VAR_AW'(i_target_slot);
        end else begin
            dec.rd1_en   = i_second_is_variable && (i_second_operand < 32'(NUM_VARIABLES));
            dec.rd1_addr = i_second_operand[VAR_AW-1:0];
        end
    end

    assign o_stall      = (r_cnt == 2'd2) || i_ctl.clearing;
    assign accept       = i_valid && !o_stall;
    assign o_item       = r_q[r_rp];
    assign o_item_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_wp <= !r_wp;
            end
            if (i_ctl.pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(accept) - 2'(i_ctl.pop);
        end
    end

endmodule

// ===== rtl/bvm_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module bvm_div import bvm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_rem,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_res
);

    logic              r_busy;
    logic [DIV_CW-1:0] r_cnt;
    logic [31:0]       r_rem, r_quo, r_mb;
    logic              r_na, r_nb, r_want;
    logic [32:0]       sh, diff;
    logic              ge;

    assign sh     = {r_rem, r_quo[31]};
    assign diff   = sh - {1'b0, r_mb};
    assign ge     = !diff[32];
    assign o_done = r_busy && (r_cnt == '0);

    always_comb begin
        if (r_want) begin
            o_res = r_na ? (32'd0 - r_rem) : r_rem;
        end else begin
            o_res = (r_na != r_nb) ? (32'd0 - r_quo) : r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_a[31] ? (32'd0 - i_a) : i_a;
            r_mb   <= i_b[31] ? (32'd0 - i_b) : i_b;
            r_na   <= i_a[31];
            r_nb   <= i_b[31];
            r_want <= i_rem;
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= ge ? diff[31:0] : sh[31:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CW'(DIV_STEPS);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/bvm_back.sv =====
// Back end: executes one instruction at a time against the variable file and stores.
module bvm_back import bvm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_item_valid,
    output t_bctl       o_ctl,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [15:0] o_next_pc,
    output logic [1:0]  o_print_kind,
    output logic [31:0] o_print_value,
    output logic [1:0]  o_fault,
    output logic        o_halted,
    output logic        o_skipping
);

    t_state               r_state, n_state;
    t_item                r_item;
    logic [STORE_AW-1:0]  r_clr;
    logic [31:0]          r_vmem [NUM_VARIABLES];
    logic [NUM_VARIABLES-1:0] r_vvalid;
    logic [31:0]          r_vd0, r_vd1;
    logic                 r_v0, r_v1;
    logic [31:0]          r_amem [1 << STORE_AW];
    logic [7:0]           r_smem [1 << STORE_AW];
    logic [31:0]          r_ard;
    logic [7:0]           r_srd;
    logic [LEN_W-1:0]     r_alen [ARRAY_COUNT];
    logic [LEN_W-1:0]     r_slen [STRING_COUNT];
    logic [LEN_W-1:0]     n_alen [ARRAY_COUNT];
    logic [LEN_W-1:0]     n_slen [STRING_COUNT];
    logic [15:0]          r_stk [STACK_DEPTH];
    logic [15:0]          r_stk_rd;
    logic [SP_W-1:0]      r_sp, n_sp;
    logic [15:0]          r_depth, n_depth;
    logic [31:0]          r_prod;
    logic                 r_gok;

    logic                 r_out_valid;
    logic [15:0]          r_out_next;
    t_pkind               r_out_kind;
    logic [31:0]          r_out_pv;
    t_fault               r_out_fault;
    logic                 r_out_halt, r_out_skip;

    logic [31:0]          a_val, b_val, t_val;
    logic                 cmp_ok, is_cmp, out_free, pop;
    logic                 a_neg, a_over_arr, a_over_str, arr_ok, str_ok;
    logic                 a_in_alen, a_in_slen;
    t_route               route;
    logic                 emit, e_halt;
    logic [15:0]          e_next;
    t_pkind               e_kind;
    logic [31:0]          e_pv;
    t_fault               e_fault;
    logic                 vw_en;
    logic [31:0]          vw_data;
    logic                 aw_en, sw_en, push_en, div_start, div_done;
    logic [STORE_AW-1:0]  st_addr;
    logic [31:0]          st_data;
    logic [STK_AW-1:0]    stk_rd_addr;
    logic [31:0]          div_res;

    bvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_rem   (r_item.op == OP_MOD),
        .i_a     (a_val),
        .i_b     (b_val),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    // operand resolution and classification of the item in execute
    always_comb begin
        a_val      = r_item.a_var ? (r_v0 ? r_vd0 : 32'd0) : r_item.a_raw;
        t_val      = r_v1 ? r_vd1 : 32'd0;
        b_val      = r_item.b_var ? t_val : r_item.b_raw;
        a_neg      = a_val[31];
        a_over_arr = a_val >= 32'(ARRAY_CAPACITY);
        a_over_str = a_val >= 32'(STRING_CAPACITY);
        arr_ok     = 32'(r_item.cont) < 32'(ARRAY_COUNT);
        str_ok     = 32'(r_item.cont) < 32'(STRING_COUNT);
        a_in_alen  = a_val < 32'(r_alen[r_item.cont]);
        a_in_slen  = a_val < 32'(r_slen[r_item.cont]);
        is_cmp     = (r_item.op == OP_GT) || (r_item.op == OP_LT) || (r_item.op == OP_EQ) ||
                     (r_item.op == OP_NE) || (r_item.op == OP_LE) || (r_item.op == OP_GE);
        case (r_item.op)
            OP_GT:   cmp_ok = $signed(a_val) >  $signed(b_val);
            OP_LT:   cmp_ok = $signed(a_val) <  $signed(b_val);
            OP_EQ:   cmp_ok = a_val == b_val;
            OP_NE:   cmp_ok = a_val != b_val;
            OP_LE:   cmp_ok = $signed(a_val) <= $signed(b_val);
            default: cmp_ok = $signed(a_val) >= $signed(b_val);
        endcase
        route = R_DONE;
        if (r_depth == 16'd0) begin
            case (r_item.op)
                OP_MUL:  route = R_MUL;
                OP_DIV,
                OP_MOD:  route = (b_val != 32'd0) ? R_DIV : R_DONE;
                OP_RET:  route = (r_sp != '0) ? R_RET : R_DONE;
                OP_AGET: route = (!a_neg && arr_ok && !a_over_arr) ? R_GET : R_DONE;
                OP_SGET: route = (!a_neg && str_ok && !a_over_str) ? R_GET : R_DONE;
                default: route = R_DONE;
            endcase
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    assign pop      = (r_state == S_IDLE) && i_item_valid && out_free;
    assign o_ctl    = '{pop: pop, clearing: (r_state == S_CLEAR)};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == '1) n_state = S_IDLE;
            S_IDLE:  if (pop) n_state = S_EXEC;
            S_EXEC: begin
                case (route)
                    R_MUL:   n_state = S_MUL;
                    R_DIV:   n_state = S_DIV;
                    R_GET:   n_state = S_GET;
                    R_RET:   n_state = S_RET;
                    default: n_state = S_IDLE;
                endcase
            end
            S_DIV:   if (div_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        emit        = 1'b0;
        e_next      = r_item.pc + 16'd1;
        e_kind      = PK_NONE;
        e_pv        = 32'd0;
        e_fault     = FLT_NONE;
        e_halt      = 1'b0;
        vw_en       = 1'b0;
        vw_data     = 32'd0;
        aw_en       = 1'b0;
        sw_en       = 1'b0;
        st_addr     = {r_item.cont, a_val[ELEM_AW-1:0]};
        st_data     = b_val;
        push_en     = 1'b0;
        div_start   = 1'b0;
        stk_rd_addr = STK_AW'(r_sp - 1'b1);
        n_sp        = r_sp;
        n_depth     = r_depth;
        n_alen      = r_alen;
        n_slen      = r_slen;
        case (r_state)
            S_CLEAR: begin
                aw_en   = 1'b1;
                sw_en   = 1'b1;
                st_addr = r_clr;
                st_data = 32'd0;
            end
            S_EXEC: begin
                emit = (route == R_DONE);
                if (r_depth != 16'd0) begin
                    // skipping: only count nesting
                    if (is_cmp) begin
                        if (r_depth != 16'hFFFF) n_depth = r_depth + 16'd1;
                    end else if (r_item.op == OP_END) begin
                        n_depth = r_depth - 16'd1;
                    end
                end else begin
                    case (r_item.op)
                        OP_SET: begin vw_en = 1'b1; vw_data = a_val; end
                        OP_ADD: begin vw_en = 1'b1; vw_data = a_val + b_val; end
                        OP_SUB: begin vw_en = 1'b1; vw_data = a_val - b_val; end
                        OP_INC: begin vw_en = 1'b1; vw_data = t_val + a_val; end
                        OP_DEC: begin vw_en = 1'b1; vw_data = t_val - a_val; end
                        OP_DIV, OP_MOD: begin
                            if (b_val == 32'd0) begin
                                vw_en   = 1'b1;
                                e_fault = FLT_DIV0;
                            end else begin
                                div_start = 1'b1;
                            end
                        end
                        OP_GT, OP_LT, OP_EQ, OP_NE, OP_LE, OP_GE: begin
                            if (!cmp_ok) n_depth = 16'd1;
                        end
                        OP_JMP: e_next = a_val[15:0];
                        OP_CALL: begin
                            if (r_sp < SP_W'(STACK_DEPTH)) begin
                                push_en = 1'b1;
                                n_sp    = r_sp + 1'b1;
                            end
                            e_next = a_val[15:0];
                        end
                        OP_RET: begin
                            if (r_sp == '0) begin
                                e_halt = 1'b1;
                                e_next = r_item.pc;
                            end else begin
                                n_sp = r_sp - 1'b1;
                            end
                        end
                        OP_ASET: begin
                            if (!a_neg) begin
                                if (!arr_ok || a_over_arr) begin
                                    e_fault = FLT_INDEX;
                                end else begin
                                    aw_en = 1'b1;
                                    if (!a_in_alen) n_alen[r_item.cont] = LEN_W'(a_val + 32'd1);
                                end
                            end
                        end
                        OP_SSET: begin
                            if (!a_neg) begin
                                if (!str_ok || a_over_str) begin
                                    e_fault = FLT_INDEX;
                                end else begin
                                    sw_en = 1'b1;
                                    if (!a_in_slen) n_slen[r_item.cont] = LEN_W'(a_val + 32'd1);
                                end
                            end
                        end
                        OP_AGET, OP_SGET: begin
                            if (route == R_DONE) begin
                                vw_en = 1'b1;
                                if (!a_neg) e_fault = FLT_INDEX;
                            end
                        end
                        OP_ALEN: begin
                            vw_en = 1'b1;
                            if (arr_ok) vw_data = 32'(r_alen[r_item.cont]);
                            else e_fault = FLT_INDEX;
                        end
                        OP_SLEN: begin
                            vw_en = 1'b1;
                            if (str_ok) vw_data = 32'(r_slen[r_item.cont]);
                            else e_fault = FLT_INDEX;
                        end
                        OP_PRN: begin e_kind = PK_NUM;  e_pv = a_val; end
                        OP_PRC: begin e_kind = PK_CHAR; e_pv = {24'd0, a_val[7:0]}; end
                        OP_INN: begin vw_en = 1'b1; vw_data = r_item.con; end
                        OP_INCH: begin vw_en = 1'b1; vw_data = {24'd0, r_item.con[7:0]}; end
                        OP_ACLR: if (arr_ok) n_alen[r_item.cont] = '0;
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                emit    = 1'b1;
                vw_en   = 1'b1;
                vw_data = r_prod;
            end
            S_DIV: begin
                emit    = div_done;
                vw_en   = div_done;
                vw_data = div_res;
            end
            S_GET: begin
                emit  = 1'b1;
                vw_en = 1'b1;
                if (r_gok) begin
                    vw_data = (r_item.op == OP_AGET) ? r_ard : {24'd0, r_srd};
                end
            end
            S_RET: begin
                emit   = 1'b1;
                e_next = r_stk_rd + 16'd1;
            end
            default: ;
        endcase
        if (32'(r_item.tgt) >= 32'(NUM_VARIABLES)) vw_en = 1'b0;
    end

    // variable file: two read ports on the queue head, one write port
    always_ff @(posedge i_clk) begin
        r_vd0 <= r_vmem[i_item.rd0_addr];
        r_vd1 <= r_vmem[i_item.rd1_addr];
        if (vw_en) begin
            r_vmem[VAR_AW'(r_item.tgt)] <= vw_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ard <= r_amem[st_addr];
        r_srd <= r_smem[st_addr];
        if (aw_en) r_amem[st_addr] <= st_data;
        if (sw_en) r_smem[st_addr] <= st_data[7:0];
    end

    always_ff @(posedge i_clk) begin
        r_stk_rd <= r_stk[stk_rd_addr];
        if (push_en) r_stk[r_sp[STK_AW-1:0]] <= r_item.pc;
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item <= i_item;
        end
        if (r_state == S_EXEC) begin
            r_prod <= a_val * b_val;
            r_gok  <= (r_item.op == OP_AGET) ? a_in_alen : a_in_slen;
        end
        if (emit) begin
            r_out_next  <= e_next;
            r_out_kind  <= e_kind;
            r_out_pv    <= e_pv;
            r_out_fault <= e_fault;
            r_out_halt  <= e_halt;
            r_out_skip  <= (n_depth != 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_vvalid    <= '0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_sp        <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ARRAY_COUNT; i++) r_alen[i] <= '0;
            for (int i = 0; i < STRING_COUNT; i++) r_slen[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            r_v0 <= i_item.rd0_en && r_vvalid[i_item.rd0_addr];
            r_v1 <= i_item.rd1_en && r_vvalid[i_item.rd1_addr];
            if (vw_en) r_vvalid[VAR_AW'(r_item.tgt)] <= 1'b1;
            r_sp    <= n_sp;
            r_depth <= n_depth;
            r_alen  <= n_alen;
            r_slen  <= n_slen;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_next_pc     = r_out_next;
    assign o_print_kind  = r_out_kind;
    assign o_print_value = r_out_pv;
    assign o_fault       = r_out_fault;
    assign o_halted      = r_out_halt;
    assign o_skipping    = r_out_skip;

endmodule

// ===== rtl/bytecode_variable_machine_executor.sv =====
// An instruction leaves the queue head in S_IDLE and runs in S_EXEC (set, add, compare ...).
// Multiply, element get and return then pass through S_MUL, S_GET or S_RET; divide and modulo
// wait in S_DIV for the bit-serial divider. The back end takes the next instruction only then.
// The variable file is read as an instruction leaves the queue and written when its result is ready.
// Reset: synchronous, active low; then a clearing pass zeroes the array and string
// stores, during which no instruction is accepted.
module bytecode_variable_machine_executor import bvm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_operation,
    input  logic [15:0] i_pc,
    input  logic [7:0]  i_target_slot,
    input  logic [3:0]  i_container_index,
    input  logic [31:0] i_first_operand,
    input  logic [31:0] i_second_operand,
    input  logic        i_first_is_variable,
    input  logic        i_second_is_variable,
    input  logic [31:0] i_console_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_next_pc,
    output logic [1:0]  o_print_kind,
    output logic [31:0] o_print_value,
    output logic [1:0]  o_fault,
    output logic        o_halted,
    output logic        o_skipping
);

    t_item item;
    logic  item_valid;
    t_bctl ctl;

    bvm_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_operation          (i_operation),
        .i_pc                 (i_pc),
        .i_target_slot        (i_target_slot),
        .i_container_index    (i_container_index),
        .i_first_operand      (i_first_operand),
        .i_second_operand     (i_second_operand),
        .i_first_is_variable  (i_first_is_variable),
        .i_second_is_variable (i_second_is_variable),
        .i_console_value      (i_console_value),
        .i_ctl                (ctl),
        .o_item               (item),
        .o_item_valid         (item_valid)
    );

    bvm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item),
        .i_item_valid  (item_valid),
        .o_ctl         (ctl),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_next_pc     (o_next_pc),
        .o_print_kind  (o_print_kind),
        .o_print_value (o_print_value),
        .o_fault       (o_fault),
        .o_halted      (o_halted),
        .o_skipping    (o_skipping)
    );

endmodule

// ===== rtl/bvm_checker.sv =====
// Port-level checks for the executor, bound to the top level.
module bvm_checker import bvm_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_next_pc,
    input logic [1:0]  o_print_kind,
    input logic [31:0] o_print_value,
    input logic [1:0]  o_fault,
    input logic        o_halted,
    input logic        o_skipping
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_next_pc) && $stable(o_print_value))
        else $error("stalled result changed");

    a_print_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_print_kind != PK_NONE |-> !o_skipping && !o_halted && o_fault == FLT_NONE)
        else $error("print beat carries other status");

    a_char_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_print_kind == PK_CHAR |-> o_print_value[31:8] == 24'd0)
        else $error("character print wider than a byte");

    a_no_print_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_print_kind == PK_NONE |-> o_print_value == 32'd0)
        else $error("print value without print kind");

    a_halt_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_halted |-> !o_skipping && o_fault == FLT_NONE)
        else $error("halt beat carries other status");

endmodule

bind bytecode_variable_machine_executor bvm_checker u_bvm_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking testbench for the bytecode variable machine executor.
`timescale 1ns / 1ps

module testbench;
    import bvm_pkg::*;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [1:0]  print_kind;
        logic [31:0] print_value;
        logic [1:0]  fault;
        logic        halted;
        logic        skipping;
    } t_outcome;

    class machine_scoreboard;
        logic [31:0] vars [NUM_VARIABLES];
        logic [31:0] arr_mem [ARRAY_COUNT*ARRAY_CAPACITY];
        int unsigned arr_len [ARRAY_COUNT];
        logic [7:0]  str_mem [STRING_COUNT*STRING_CAPACITY];
        int unsigned str_len [STRING_COUNT];
        logic [15:0] ret_stack [STACK_DEPTH];
        int unsigned depth_sp;
        int unsigned skip_level;
        t_outcome    pending [$];
        int          mismatches;

        function void clear_state();
            foreach (vars[i]) vars[i] = '0;
            foreach (arr_mem[i]) arr_mem[i] = '0;
            foreach (str_mem[i]) str_mem[i] = '0;
            foreach (arr_len[i]) arr_len[i] = 0;
            foreach (str_len[i]) str_len[i] = 0;
            depth_sp = 0;
            skip_level = 0;
            mismatches = 0;
        endfunction

        function logic [31:0] rd(logic [31:0] idx);
            return (idx < NUM_VARIABLES) ? vars[idx] : 32'd0;
        endfunction

        function void wr(logic [7:0] idx, logic [31:0] v);
            vars[idx] = v;
        endfunction

        function logic holds(t_op op, logic [31:0] a, logic [31:0] b);
            case (op)
                OP_GT: return $signed(a) > $signed(b);
                OP_LT: return $signed(a) < $signed(b);
                OP_EQ: return a == b;
                OP_NE: return a != b;
                OP_LE: return $signed(a) <= $signed(b);
                default: return $signed(a) >= $signed(b);
            endcase
        endfunction

        function logic [31:0] quot(logic [31:0] a, logic [31:0] b, logic rem);
            logic [31:0] ma, mb, q, r;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            r = ma % mb;
            if (rem) return a[31] ? -r : r;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        function void note_instruction(logic [4:0] opc, logic [15:0] pc, logic [7:0] tgt,
                                       logic [3:0] cont, logic [31:0] ar, logic [31:0] br,
                                       logic av, logic bv, logic [31:0] con);
            t_outcome o;
            t_op op;
            logic [31:0] a, b, v;
            op = t_op'(opc);
            a = av ? rd(ar) : ar;
            b = bv ? rd(br) : br;
            o = '{pc + 16'd1, PK_NONE, 32'd0, FLT_NONE, 1'b0, 1'b0};
            if (skip_level != 0) begin
                if (opc >= OP_GT && opc <= OP_GE) begin
                    if (skip_level < 65535) skip_level++;
                end else if (opc == OP_END) begin
                    skip_level--;
                end
            end else begin
                case (opc)
                    OP_SET: wr(tgt, a);
                    OP_ADD: wr(tgt, a + b);
                    OP_SUB: wr(tgt, a - b);
                    OP_MUL: wr(tgt, a * b);
                    OP_DIV, OP_MOD: begin
                        if (b == 0) begin
                            o.fault = FLT_DIV0;
                            wr(tgt, 0);
                        end else wr(tgt, quot(a, b, opc == OP_MOD));
                    end
                    OP_INC: wr(tgt, vars[tgt] + a);
                    OP_DEC: wr(tgt, vars[tgt] - a);
                    OP_GT, OP_LT, OP_EQ, OP_NE, OP_LE, OP_GE:
                        if (!holds(op, a, b)) skip_level = 1;
                    OP_JMP: o.next_pc = a[15:0];
                    OP_CALL: begin
                        if (depth_sp < STACK_DEPTH) begin
                            ret_stack[depth_sp] = pc;
                            depth_sp++;
                        end
                        o.next_pc = a[15:0];
                    end
                    OP_RET: begin
                        if (depth_sp == 0) begin
                            o.halted = 1'b1;
                            o.next_pc = pc;
                        end else begin
                            depth_sp--;
                            o.next_pc = ret_stack[depth_sp] + 16'd1;
                        end
                    end
                    OP_ASET: begin
                        if (!a[31]) begin
                            if (a >= ARRAY_CAPACITY) o.fault = FLT_INDEX;
                            else begin
                                arr_mem[cont*ARRAY_CAPACITY + a] = b;
                                if (a >= arr_len[cont]) arr_len[cont] = a + 1;
                            end
                        end
                    end
                    OP_SSET: begin
                        if (!a[31]) begin
                            if (a >= STRING_CAPACITY) o.fault = FLT_INDEX;
                            else begin
                                str_mem[cont*STRING_CAPACITY + a] = b[7:0];
                                if (a >= str_len[cont]) str_len[cont] = a + 1;
                            end
                        end
                    end
                    OP_AGET: begin
                        v = 0;
                        if (!a[31]) begin
                            if (a >= ARRAY_CAPACITY) o.fault = FLT_INDEX;
                            else if (a < arr_len[cont]) v = arr_mem[cont*ARRAY_CAPACITY + a];
                        end
                        wr(tgt, v);
                    end
                    OP_SGET: begin
                        v = 0;
                        if (!a[31]) begin
                            if (a >= STRING_CAPACITY) o.fault = FLT_INDEX;
                            else if (a < str_len[cont]) begin
                                v = {24'd0, str_mem[cont*STRING_CAPACITY + a]};
                            end
                        end
                        wr(tgt, v);
                    end
                    OP_ALEN: wr(tgt, arr_len[cont]);
                    OP_SLEN: wr(tgt, str_len[cont]);
                    OP_PRN: begin
                        o.print_kind = PK_NUM;
                        o.print_value = a;
                    end
                    OP_PRC: begin
                        o.print_kind = PK_CHAR;
                        o.print_value = {24'd0, a[7:0]};
                    end
                    OP_INN: wr(tgt, con);
                    OP_INCH: wr(tgt, {24'd0, con[7:0]});
                    OP_ACLR: arr_len[cont] = 0;
                    default: ;
                endcase
            end
            o.skipping = (skip_level != 0);
            pending.push_back(o);
        endfunction

        function void check_result(t_outcome got);
            t_outcome e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat at %0t", $time);
                return;
            end
            e = pending.pop_front();
            if (got != e) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t:", $time);
                    $display("  exp pc=%h pk=%0d pv=%h f=%0d h=%b s=%b",
                             e.next_pc, e.print_kind, e.print_value, e.fault, e.halted,
                             e.skipping);
                    $display("  got pc=%h pk=%0d pv=%h f=%0d h=%b s=%b",
                             got.next_pc, got.print_kind, got.print_value, got.fault,
                             got.halted, got.skipping);
                end
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_valid, i_stall;
    logic        o_stall, o_valid;
    logic [4:0]  i_operation;
    logic [15:0] i_pc;
    logic [7:0]  i_target_slot;
    logic [3:0]  i_container_index;
    logic [31:0] i_first_operand, i_second_operand, i_console_value;
    logic        i_first_is_variable, i_second_is_variable;
    logic [15:0] o_next_pc;
    logic [1:0]  o_print_kind, o_fault;
    logic [31:0] o_print_value;
    logic        o_halted, o_skipping;

    machine_scoreboard board;
    longint      cycle_count;

    bytecode_variable_machine_executor dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Drive one instruction beat and hold it until accepted.
    task automatic send_instruction(logic [4:0] op, logic [15:0] pc, logic [7:0] tgt,
                                    logic [3:0] cont, logic [31:0] a, logic [31:0] b,
                                    logic av, logic bv, logic [31:0] con);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_pc <= pc;
        i_target_slot <= tgt;
        i_container_index <= cont;
        i_first_operand <= a;
        i_second_operand <= b;
        i_first_is_variable <= av;
        i_second_is_variable <= bv;
        i_console_value <= con;
        do @(posedge i_clk); while (o_stall);
        board.note_instruction(op, pc, tgt, cont, a, b, av, bv, con);
    endtask

    function logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 8);
            1: return -$urandom_range(1, 8);
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function logic [31:0] rand_index();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return -$urandom_range(1, 4);
            2: return $urandom_range(256, 300);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    task automatic random_instruction();
        logic [4:0] op;
        int r;
        logic av, bv;
        logic [31:0] a, b;
        r = $urandom_range(0, 99);
        if (r < 12) op = 5'($urandom_range(OP_GT, OP_GE));
        else if (r < 22) op = OP_END;
        else if (r < 30) op = 5'($urandom_range(OP_CALL, OP_RET));
        else if (r < 31) op = 5'($urandom_range(30, 31));
        else op = 5'($urandom_range(0, 29));
        av = $urandom_range(0, 2) == 0;
        bv = $urandom_range(0, 2) == 0;
        a = av ? rand_index() : ((op >= OP_ASET && op <= OP_SGET) ? rand_index() : rand_value());
        b = bv ? rand_index() : rand_value();
        // Keep the variable file in reach for operand reads.
        if (av && $urandom_range(0, 3) != 0) a = $urandom_range(0, 255);
        if (bv && $urandom_range(0, 3) != 0) b = $urandom_range(0, 255);
        send_instruction(op, 16'($urandom), 8'($urandom), 4'($urandom), a, b, av, bv,
                         $urandom);
    endtask

    // Randomly stall the result channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                board.check_result('{o_next_pc, o_print_kind, o_print_value, o_fault,
                                     o_halted, o_skipping});
            end
            i_stall <= (pick_gap() > 0) && ($urandom_range(0, 1) == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        board = new();
        board.clear_state();
        cycle_count = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_operation = OP_NOP;
        i_pc = 0;
        i_target_slot = 0;
        i_container_index = 0;
        i_first_operand = 0;
        i_second_operand = 0;
        i_first_is_variable = 0;
        i_second_is_variable = 0;
        i_console_value = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, each opcode apart from GT, NE, LE and GE, special cases.
        send_instruction(OP_RET, 16'h0000, 0, 0, 0, 0, 0, 0, 0);
        send_instruction(OP_SET, 16'hffff, 8'd1, 0, 32'h8000_0000, 0, 0, 0, 0);
        send_instruction(OP_DIV, 16'd2, 8'd2, 0, 1, 32'hffff_ffff, 1, 0, 0);
        send_instruction(OP_MOD, 16'd3, 8'd3, 0, 1, 32'hffff_ffff, 1, 0, 0);
        send_instruction(OP_DIV, 16'd4, 8'd4, 0, 7, 0, 0, 0, 0);
        send_instruction(OP_MOD, 16'd5, 8'd5, 0, -7, 2, 0, 0, 0);
        send_instruction(OP_MUL, 16'd6, 8'd6, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0);
        send_instruction(OP_ADD, 16'd7, 8'd255, 0, 32'h7fff_ffff, 1, 0, 0, 0);
        send_instruction(OP_SUB, 16'd8, 8'd7, 0, 300, -1, 1, 0, 0);
        send_instruction(OP_INC, 16'd9, 8'd7, 0, 5, 0, 0, 0, 0);
        send_instruction(OP_DEC, 16'd10, 8'd7, 0, 32'hffff_ffff, 0, 0, 0, 0);
        send_instruction(OP_ASET, 16'd11, 0, 4'd15, 255, 32'hdead_beef, 0, 0, 0);
        send_instruction(OP_ASET, 16'd12, 0, 4'd15, 256, 1, 0, 0, 0);
        send_instruction(OP_AGET, 16'd13, 8'd8, 4'd15, 255, 0, 0, 0, 0);
        send_instruction(OP_AGET, 16'd14, 8'd9, 4'd15, -1, 0, 0, 0, 0);
        send_instruction(OP_ALEN, 16'd15, 8'd10, 4'd15, 0, 0, 0, 0, 0);
        send_instruction(OP_SSET, 16'd16, 0, 4'd0, 3, 32'h1ff, 0, 0, 0);
        send_instruction(OP_SGET, 16'd17, 8'd11, 4'd0, 3, 0, 0, 0, 0);
        send_instruction(OP_SLEN, 16'd18, 8'd12, 4'd0, 0, 0, 0, 0, 0);
        send_instruction(OP_ACLR, 16'd19, 0, 4'd15, 0, 0, 0, 0, 0);
        send_instruction(OP_PRN, 16'd20, 0, 0, 1, 0, 1, 0, 0);
        send_instruction(OP_PRC, 16'd21, 0, 0, 32'h1234_56ff, 0, 0, 0, 0);
        send_instruction(OP_INN, 16'd22, 8'd13, 0, 0, 0, 0, 0, 32'h8000_0000);
        send_instruction(OP_INCH, 16'd23, 8'd14, 0, 0, 0, 0, 0, 32'hffff_ffff);
        send_instruction(OP_CALL, 16'd24, 0, 0, 32'hffff, 0, 0, 0, 0);
        send_instruction(OP_RET, 16'hffff, 0, 0, 0, 0, 0, 0, 0);
        send_instruction(OP_JMP, 16'd26, 0, 0, 32'h0001_abcd, 0, 0, 0, 0);
        send_instruction(OP_EQ, 16'd27, 0, 0, 1, 2, 0, 0, 0);
        send_instruction(OP_LT, 16'd28, 0, 0, 1, 2, 0, 0, 0);
        send_instruction(OP_PRN, 16'd29, 0, 0, 9, 0, 0, 0, 0);
        send_instruction(OP_END, 16'd30, 0, 0, 0, 0, 0, 0, 0);
        send_instruction(OP_END, 16'd31, 0, 0, 0, 0, 0, 0, 0);
        send_instruction(OP_NOP, 16'd32, 0, 0, 0, 0, 0, 0, 0);

        // Fill the return stack past its depth, then drain it below empty.
        repeat (STACK_DEPTH + 2)
            send_instruction(OP_CALL, 16'($urandom), 0, 0, $urandom, 0, 0, 0, 0);
        repeat (STACK_DEPTH + 2)
            send_instruction(OP_RET, 16'($urandom), 0, 0, 0, 0, 0, 0, 0);

        repeat (1450) random_instruction();
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
